### hw/rtl/gsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_pkg: shared definitions for the generic selection resolver
// Widths, status codes and the records passed along the comparison chain.
// ----------------------------------------------------------------------------
package gsr_pkg;

    // Capacity and field widths.
    localparam int MAX_ASSOC = 16;
    localparam int TYPE_BITS = 16;
    localparam int QUAL_BITS = 8;
    localparam int IDX_W     = 5;
    localparam int CNT_W     = $clog2(MAX_ASSOC + 1);
    localparam int SLOT_W    = $clog2(MAX_ASSOC);

    // Index value that means "none".
    localparam logic [IDX_W-1:0] IDX_NONE = '1;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_NO_MATCH   = 3'd1,
        STAT_DUP_DEFAULT= 3'd2,
        STAT_DUP_TYPE   = 3'd3,
        STAT_UNRESOLVED = 3'd4,
        STAT_OVERFLOW   = 3'd5
    } status_t;

    // One stored association.
    typedef struct packed {
        logic [TYPE_BITS-1:0] type_id;
        logic [QUAL_BITS-1:0] qual;
        logic                 dflt;
    } entry_t;

    // Search probe that walks the chain one cell per cycle.
    typedef struct packed {
        logic                 valid;
        logic [TYPE_BITS-1:0] type_id;
        logic [QUAL_BITS-1:0] qual;
        logic                 hit;
    } probe_t;

    // Controls from the sequencer to the row of cells.
    typedef struct packed {
        logic [MAX_ASSOC-1:0] wr_sel;
        logic [MAX_ASSOC-1:0] live;
        entry_t               wr_entry;
    } chain_ctl_t;

endpackage

### hw/rtl/generic_selection_resolver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generic_selection_resolver_unit: type-keyed selection resolver
// A begin transfer sets the controlling type; association transfers follow
// and the transfer marked last yields a status, a chosen index and a clash index.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Contents
//  cfg     | in        | cfg_wr_en          | invalid type code
//  in      | in        | in_valid/in_stall  | command, type_id, qualifiers,
//          |           |                    | default_flag, last
//  out     | out       | out_valid/out_stall| status, chosen_index,
//          |           |                    | clash_index
//
// A begin transfer, or an association that needs no duplicate search, is done
// without entering the search state. An association with earlier stored entries
// sends a probe down the row of MAX_ASSOC cells, one cell per cycle, and no
// further transfer is taken until the probe has returned.
// Reset clears all control state; stored entries are not cleared, as only
// entries written in the open selection are ever compared.
// Input is stalled during a search and while an untaken result is held.
// ----------------------------------------------------------------------------
module generic_selection_resolver_unit
    import gsr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [TYPE_BITS-1:0]    cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    command,
    input  logic [TYPE_BITS-1:0]    type_id,
    input  logic [QUAL_BITS-1:0]    qualifiers,
    input  logic                    default_flag,
    input  logic                    last,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              status,
    output logic signed [IDX_W-1:0] chosen_index,
    output logic signed [IDX_W-1:0] clash_index
);

    chain_ctl_t       chain_ctl;
    probe_t           chain_probe [MAX_ASSOC+1];
    logic [IDX_W-1:0] sel_idx;
    logic [IDX_W-1:0] conf_idx;

    // Sequencer.
    gsr_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .type_id        (type_id),
        .qualifiers     (qualifiers),
        .default_flag   (default_flag),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .chosen_index   (sel_idx),
        .clash_index    (conf_idx),
        .chain_ctl      (chain_ctl),
        .probe_launch   (chain_probe[0]),
        .probe_ret      (chain_probe[MAX_ASSOC])
    );

    // Row of association cells; the probe moves one cell per cycle.
    for (genvar k = 0; k < MAX_ASSOC; k++)
    begin : g_cell
        gsr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (chain_ctl.wr_sel[k]),
            .live      (chain_ctl.live[k]),
            .wr_entry  (chain_ctl.wr_entry),
            .probe_in  (chain_probe[k]),
            .probe_out (chain_probe[k+1])
        );
    end

    assign chosen_index = $signed(sel_idx);
    assign clash_index  = $signed(conf_idx);

endmodule

### hw/rtl/gsr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_cell: one slot of the association chain
// Holds one stored association and compares the passing probe against it.
// ----------------------------------------------------------------------------
module gsr_cell
    import gsr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  logic   live,
    input  entry_t wr_entry,
    input  probe_t probe_in,
    output probe_t probe_out
);

    entry_t entry_reg;
    probe_t probe_reg;
    probe_t probe_next;
    logic   same;

    // The stored entry is written once per association and needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_entry;
        end
    end

    // A live, non-default entry equal to the probe marks it as a duplicate.
    always_comb
    begin
        same = live && !entry_reg.dflt &&
               (entry_reg.type_id == probe_in.type_id) &&
               (entry_reg.qual == probe_in.qual);
        probe_next     = probe_in;
        probe_next.hit = probe_in.hit | (probe_in.valid & same);
    end

    // Hand the probe on to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;

endmodule

### hw/rtl/gsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_ctrl: selection sequencer
// Takes transfers, keeps the selection state, launches duplicate searches
// down the cell chain and forms the registered result.
// ----------------------------------------------------------------------------
module gsr_ctrl
    import gsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [TYPE_BITS-1:0] cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [TYPE_BITS-1:0] type_id,
    input  logic [QUAL_BITS-1:0] qualifiers,
    input  logic                 default_flag,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [IDX_W-1:0]     chosen_index,
    output logic [IDX_W-1:0]     clash_index,
    output chain_ctl_t           chain_ctl,
    output probe_t               probe_launch,
    input  probe_t               probe_ret
);

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } ctrl_state_t;

    ctrl_state_t          state_reg,     state_next;
    logic [TYPE_BITS-1:0] inv_code_reg,  inv_code_next;
    logic [TYPE_BITS-1:0] ctl_type_reg,  ctl_type_next;
    logic [QUAL_BITS-1:0] ctl_qual_reg,  ctl_qual_next;
    logic                 ctl_inv_reg,   ctl_inv_next;
    logic [CNT_W-1:0]     count_reg,     count_next;
    logic [IDX_W-1:0]     dflt_pos_reg,  dflt_pos_next;
    logic [IDX_W-1:0]     match_pos_reg, match_pos_next;
    status_t              err_code_reg,  err_code_next;
    logic [IDX_W-1:0]     err_pos_reg,   err_pos_next;
    logic [TYPE_BITS-1:0] pend_type_reg, pend_type_next;
    logic [QUAL_BITS-1:0] pend_qual_reg, pend_qual_next;
    logic                 pend_last_reg, pend_last_next;
    probe_t               probe_reg,     probe_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_stat_reg,  out_stat_next;
    logic [IDX_W-1:0]     out_sel_reg,   out_sel_next;
    logic [IDX_W-1:0]     out_conf_reg,  out_conf_next;

    logic                 out_free;
    logic                 accept;
    logic                 finish;
    logic [IDX_W-1:0]     cur_idx;
    logic                 ctl_equal;

    // Input is taken only when idle and the result register is free.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;
    assign cur_idx  = IDX_W'(count_reg);

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        inv_code_next  = cfg_wr_en ? cfg_wr_data : inv_code_reg;
        ctl_type_next  = ctl_type_reg;
        ctl_qual_next  = ctl_qual_reg;
        ctl_inv_next   = ctl_inv_reg;
        count_next     = count_reg;
        dflt_pos_next  = dflt_pos_reg;
        match_pos_next = match_pos_reg;
        err_code_next  = err_code_reg;
        err_pos_next   = err_pos_reg;
        pend_type_next = pend_type_reg;
        pend_qual_next = pend_qual_reg;
        pend_last_next = pend_last_reg;
        probe_next     = '0;
        out_valid_next = out_valid_reg && out_stall;
        out_stat_next  = out_stat_reg;
        out_sel_next   = out_sel_reg;
        out_conf_next  = out_conf_reg;
        finish         = 1'b0;
        ctl_equal      = 1'b0;

        chain_ctl          = '0;
        chain_ctl.wr_entry = '{type_id: type_id, qual: qualifiers, dflt: default_flag};
        for (int k = 0; k < MAX_ASSOC; k++)
        begin
            chain_ctl.live[k] = (CNT_W'(k) < count_reg);
        end

        if (accept && !command)
        begin
            // Begin transfer: load the controlling type and open a new list; if last, report unresolved.
            ctl_type_next  = type_id;
            ctl_qual_next  = qualifiers;
            ctl_inv_next   = (type_id == inv_code_reg);
            count_next     = '0;
            dflt_pos_next  = IDX_NONE;
            match_pos_next = IDX_NONE;
            err_code_next  = STAT_OK;
            err_pos_next   = IDX_NONE;
            if (last)
            begin
                out_valid_next = 1'b1;
                out_stat_next  = STAT_UNRESOLVED;
                out_sel_next   = IDX_NONE;
                out_conf_next  = IDX_NONE;
            end
        end
        else if (accept)
        begin
            // Association transfer.
            finish = last;
            if (count_reg >= CNT_W'(MAX_ASSOC))
            begin
                if (err_code_reg == STAT_OK)
                begin
                    err_code_next = STAT_OVERFLOW;
                    err_pos_next  = IDX_NONE;
                end
            end
            else
            begin
                chain_ctl.wr_sel[count_reg[SLOT_W-1:0]] = 1'b1;
                count_next = count_reg + CNT_W'(1);
                if (err_code_reg != STAT_OK)
                begin
                    // A sticky error stops all further checks.
                end
                else if (default_flag)
                begin
                    if (!dflt_pos_reg[IDX_W-1])
                    begin
                        err_code_next = STAT_DUP_DEFAULT;
                        err_pos_next  = cur_idx;
                    end
                    else
                    begin
                        dflt_pos_next = cur_idx;
                    end
                end
                else if (type_id == inv_code_reg)
                begin
                    err_code_next = STAT_UNRESOLVED;
                    err_pos_next  = cur_idx;
                end
                else if (count_reg == '0)
                begin
                    if (match_pos_reg[IDX_W-1] && type_id == ctl_type_reg &&
                        qualifiers == ctl_qual_reg)
                    begin
                        match_pos_next = cur_idx;
                    end
                end
                else
                begin
                    // Earlier entries exist: walk the chain for a duplicate.
                    count_next         = count_reg;
                    finish             = 1'b0;
                    state_next         = ST_SEARCH;
                    pend_type_next     = type_id;
                    pend_qual_next     = qualifiers;
                    pend_last_next     = last;
                    probe_next.valid   = 1'b1;
                    probe_next.type_id = type_id;
                    probe_next.qual    = qualifiers;
                    probe_next.hit     = 1'b0;
                end
            end
        end
        else if (state_reg == ST_SEARCH && probe_ret.valid)
        begin
            // The probe has passed every cell.
            state_next = ST_IDLE;
            count_next = count_reg + CNT_W'(1);
            finish     = pend_last_reg;
            ctl_equal  = (pend_type_reg == ctl_type_reg) && (pend_qual_reg == ctl_qual_reg);
            if (probe_ret.hit)
            begin
                err_code_next = STAT_DUP_TYPE;
                err_pos_next  = cur_idx;
            end
            else if (match_pos_reg[IDX_W-1] && ctl_equal)
            begin
                match_pos_next = cur_idx;
            end
        end

        // Close the selection: form the result and clear the list.
        if (finish)
        begin
            out_valid_next = 1'b1;
            out_sel_next   = IDX_NONE;
            out_conf_next  = IDX_NONE;
            if (ctl_inv_reg)
            begin
                out_stat_next = STAT_UNRESOLVED;
            end
            else if (err_code_next == STAT_OVERFLOW)
            begin
                out_stat_next = STAT_OVERFLOW;
            end
            else if (err_code_next != STAT_OK)
            begin
                out_stat_next = err_code_next;
                out_conf_next = err_pos_next;
            end
            else if (!match_pos_next[IDX_W-1])
            begin
                out_stat_next = STAT_OK;
                out_sel_next  = match_pos_next;
            end
            else if (!dflt_pos_next[IDX_W-1])
            begin
                out_stat_next = STAT_OK;
                out_sel_next  = dflt_pos_next;
            end
            else
            begin
                out_stat_next = STAT_NO_MATCH;
            end
            count_next     = '0;
            dflt_pos_next  = IDX_NONE;
            match_pos_next = IDX_NONE;
            err_code_next  = STAT_OK;
            err_pos_next   = IDX_NONE;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            inv_code_reg  <= '0;
            ctl_type_reg  <= '0;
            ctl_qual_reg  <= '0;
            ctl_inv_reg   <= 1'b0;
            count_reg     <= '0;
            dflt_pos_reg  <= IDX_NONE;
            match_pos_reg <= IDX_NONE;
            err_code_reg  <= STAT_OK;
            err_pos_reg   <= IDX_NONE;
            pend_type_reg <= '0;
            pend_qual_reg <= '0;
            pend_last_reg <= 1'b0;
            probe_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_stat_reg  <= STAT_OK;
            out_sel_reg   <= IDX_NONE;
            out_conf_reg  <= IDX_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            inv_code_reg  <= inv_code_next;
            ctl_type_reg  <= ctl_type_next;
            ctl_qual_reg  <= ctl_qual_next;
            ctl_inv_reg   <= ctl_inv_next;
            count_reg     <= count_next;
            dflt_pos_reg  <= dflt_pos_next;
            match_pos_reg <= match_pos_next;
            err_code_reg  <= err_code_next;
            err_pos_reg   <= err_pos_next;
            pend_type_reg <= pend_type_next;
            pend_qual_reg <= pend_qual_next;
            pend_last_reg <= pend_last_next;
            probe_reg     <= probe_next;
            out_valid_reg <= out_valid_next;
            out_stat_reg  <= out_stat_next;
            out_sel_reg   <= out_sel_next;
            out_conf_reg  <= out_conf_next;
        end
    end

    assign probe_launch = probe_reg;
    assign out_valid    = out_valid_reg;
    assign status       = out_stat_reg;
    assign chosen_index = out_sel_reg;
    assign clash_index  = out_conf_reg;

`ifndef ASSERT_OFF
    // No result may be pending while a search is under way.
    a_search_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |-> !out_valid_reg)
        else $error("result register occupied during search");

    // A probe returns only to a waiting sequencer.
    a_return_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        probe_ret.valid |-> state_reg == ST_SEARCH)
        else $error("probe returned outside a search");

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ASSOC))
        else $error("association count above capacity");

    // A failing result never carries a selection.
    a_error_no_select: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stat_reg != STAT_OK |-> out_sel_reg == IDX_NONE)
        else $error("error result with a selected index");
`endif

endmodule
